FILE: rtl/sblf_pkg.sv
// Shared types and constants for the store byte-lane formatter.
// Used by sblf_format and store_byte_lane_formatter; depends on nothing.
package sblf_pkg;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_ATOMIC_EN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPLIT_EN  = 2'd1;

    localparam logic [1:0] FIFO_DEPTH = 2'd2;

    typedef struct packed {
        logic [63:0] store_address;
        logic [63:0] store_value;
        logic [3:0]  byte_count;
        logic        crosses_page;
        logic        is_atomic;
        logic [63:0] instr_pc;
    } item_t;

    typedef struct packed {
        logic [63:0] record_address;
        logic [63:0] record_data;
        logic [7:0]  lane_mask;
        logic [63:0] record_pc;
        logic        bad_length;
        logic        last_record;
    } rec_t;

endpackage

FILE: rtl/sblf_format.sv
// Combinational record builder: turns one store item into zero, one or two records.
// Depends on sblf_pkg for item_t and rec_t.
module sblf_format (
    input  sblf_pkg::item_t item,
    input  logic            atomic_en,
    input  logic            split_en,
    output logic [1:0]      rec_count,
    output sblf_pkg::rec_t  rec_lo,
    output sblf_pkg::rec_t  rec_hi
);

    function automatic logic [63:0] lanes_to_bits(input logic [7:0] m);
        logic [63:0] b;
        for (int i = 0; i < 8; i++)
        begin
            b[8*i +: 8] = {8{m[i]}};
        end
        return b;
    endfunction

    logic [3:0]  len;
    logic [3:0]  len_m1;
    logic        pow2;
    logic        odd_ok;
    logic        legal;
    logic        drop;
    logic        split_case;
    logic        in_half;
    logic [7:0]  lane_m;
    logic [63:0] dm;
    logic [5:0]  end_sum;
    logic [3:0]  o16;
    logic [63:0] in_d;
    logic [7:0]  in_m;
    logic [2:0]  r;
    logic [3:0]  lo_sh4;
    logic [2:0]  lo_sh;
    logic [3:0]  hs4;
    logic [2:0]  hs;
    logic [7:0]  lo_lanes;
    logic [7:0]  hi_lanes;
    logic [63:0] lo_d;
    logic [63:0] hi_d;
    logic [2:0]  off;

    always_comb
    begin
        len    = item.byte_count;
        len_m1 = len - 4'd1;
        pow2   = (len == 4'd1) || (len == 4'd2) || (len == 4'd4) || (len == 4'd8);
        odd_ok = split_en && item.crosses_page &&
                 ((len == 4'd3) || (len == 4'd5) || (len == 4'd6) || (len == 4'd7));
        legal  = pow2 || odd_ok;
        drop   = item.is_atomic && !atomic_en;

        for (int i = 0; i < 8; i++)
        begin
            lane_m[i] = (len > 4'(i));
        end
        dm = item.store_value & lanes_to_bits(lane_m);

        split_case = split_en && pow2 && !item.crosses_page &&
                     ((item.store_address[2:0] & len_m1[2:0]) != 3'd0);
        end_sum = {1'b0, item.store_address[4:0]} + {2'b00, len_m1};
        in_half = (item.store_address[4] == end_sum[4]);

        o16 = item.store_address[3:0];
        if (o16 > 4'd8)
            in_d = 64'd0;
        else if (o16 == 4'd8)
            in_d = {dm[0], 63'd0};
        else
            in_d = dm << {o16[2:0], 3'b000};
        in_m = lane_m << o16;

        r        = item.store_address[2:0] & len_m1[2:0];
        lo_sh4   = 4'd8 - len + {1'b0, r};
        lo_sh    = lo_sh4[2:0];
        hs4      = len - {1'b0, r};
        hs       = hs4[2:0];
        lo_lanes = lane_m >> r;
        hi_lanes = lane_m >> hs;
        lo_d     = (item.store_value & lanes_to_bits(lo_lanes)) << {lo_sh, 3'b000};
        hi_d     = (item.store_value >> {hs, 3'b000}) & lanes_to_bits(hi_lanes);

        off = item.store_address[2:0];

        rec_lo.record_address = {item.store_address[63:3], 3'b000};
        rec_lo.record_data    = 64'd0;
        rec_lo.lane_mask      = 8'd0;
        rec_lo.record_pc      = item.instr_pc;
        rec_lo.bad_length     = 1'b0;
        rec_lo.last_record    = 1'b1;

        rec_hi.record_address = {item.store_address[63:4] + 60'd1, 4'b0000};
        rec_hi.record_data    = hi_d;
        rec_hi.lane_mask      = hi_lanes;
        rec_hi.record_pc      = item.instr_pc;
        rec_hi.bad_length     = 1'b0;
        rec_hi.last_record    = 1'b1;

        rec_count = 2'd1;
        if (drop)
        begin
            rec_count = 2'd0;
        end
        else if (!legal)
        begin
            rec_lo.bad_length = 1'b1;
        end
        else if (split_case && in_half)
        begin
            rec_lo.record_address = {item.store_address[63:4], 4'b0000};
            rec_lo.record_data    = in_d;
            rec_lo.lane_mask      = in_m;
        end
        else if (split_case)
        begin
            rec_lo.record_data = lo_d;
            rec_lo.lane_mask   = lo_lanes << lo_sh;
            rec_lo.last_record = 1'b0;
            rec_count          = 2'd2;
        end
        else if (len == 4'd8)
        begin
            rec_lo.record_data = item.store_value;
            rec_lo.lane_mask   = 8'hff;
        end
        else
        begin
            rec_lo.record_data = dm << {off, 3'b000};
            rec_lo.lane_mask   = lane_m << off;
        end
    end

endmodule

FILE: rtl/store_byte_lane_formatter.sv
// Store byte-lane formatter top level: input register, record builder, two-entry result queue.
// Depends on sblf_pkg and sblf_format.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one committed store per item.
//   Output channel (out_valid / out_stall) delivers store records, one per item
//   handshake; last_record marks the final record of each store.
//   Config channel (cfg_valid / cfg_ready) writes atomic enable (index 0) and
//   split enable (index 1); cfg_ready is always high. Write only while idle.
// Path: a store is captured in the input register, then its records are written into the
//   result queue, whose head is offered; a full queue holds the store in the input register.
// Throughput: one store per cycle while in_stall is low; a split store yields two records,
//   which the two-entry result queue drains one record per cycle.
//   Dropped atomic stores pass through the input register and produce nothing.
// Reset: queue and input register empty, atomic enable 0, split enable 1.
// Stall: out_stall holds the head record; the queue absorbs one more record and
//   the input register one more store, then in_stall rises until space opens.
module store_byte_lane_formatter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [63:0]                      store_address,
    input  logic [63:0]                      store_value,
    input  logic [3:0]                       byte_count,
    input  logic                             crosses_page,
    input  logic                             is_atomic,
    input  logic [63:0]                      instr_pc,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [63:0]                      record_address,
    output logic [63:0]                      record_data,
    output logic [7:0]                       lane_mask,
    output logic [63:0]                      record_pc,
    output logic                             bad_length,
    output logic                             last_record,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sblf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                             cfg_data
);

    logic            atomic_en_reg;
    logic            split_en_reg;
    logic            a_valid_reg;
    logic            a_valid_next;
    sblf_pkg::item_t a_item_reg;
    sblf_pkg::rec_t  q0_reg;
    sblf_pkg::rec_t  q0_next;
    sblf_pkg::rec_t  q1_reg;
    sblf_pkg::rec_t  q1_next;
    logic [1:0]      q_cnt_reg;
    logic [1:0]      q_cnt_next;

    logic [1:0]      need;
    sblf_pkg::rec_t  rec_lo;
    sblf_pkg::rec_t  rec_hi;
    logic            pop;
    logic [2:0]      space;
    logic            a_adv;
    logic            accept;
    logic [1:0]      base_cnt;

    sblf_format u_format (
        .item      (a_item_reg),
        .atomic_en (atomic_en_reg),
        .split_en  (split_en_reg),
        .rec_count (need),
        .rec_lo    (rec_lo),
        .rec_hi    (rec_hi)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atomic_en_reg <= 1'b0;
            split_en_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sblf_pkg::REG_ATOMIC_EN: atomic_en_reg <= cfg_data;
                sblf_pkg::REG_SPLIT_EN:  split_en_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        pop      = (q_cnt_reg != 2'd0) && !out_stall;
        space    = {1'b0, sblf_pkg::FIFO_DEPTH} - {1'b0, q_cnt_reg} + {2'b00, pop};
        a_adv    = a_valid_reg && ({1'b0, need} <= space);
        in_stall = a_valid_reg && !a_adv;
        accept   = in_valid && !in_stall;

        a_valid_next = accept ? 1'b1 : (a_adv ? 1'b0 : a_valid_reg);

        base_cnt = q_cnt_reg - {1'b0, pop};
        q0_next  = pop ? q1_reg : q0_reg;
        q1_next  = q1_reg;
        if (a_adv && (need != 2'd0))
        begin
            if (base_cnt == 2'd0)
                q0_next = rec_lo;
            else
                q1_next = rec_lo;
            if (need == 2'd2)
                q1_next = rec_hi;
        end
        q_cnt_next = a_adv ? (base_cnt + need) : base_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            q_cnt_reg   <= 2'd0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            q_cnt_reg   <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg.store_address <= store_address;
            a_item_reg.store_value   <= store_value;
            a_item_reg.byte_count    <= byte_count;
            a_item_reg.crosses_page  <= crosses_page;
            a_item_reg.is_atomic     <= is_atomic;
            a_item_reg.instr_pc      <= instr_pc;
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign out_valid      = (q_cnt_reg != 2'd0);
    assign record_address = q0_reg.record_address;
    assign record_data    = q0_reg.record_data;
    assign lane_mask      = q0_reg.lane_mask;
    assign record_pc      = q0_reg.record_pc;
    assign bad_length     = q0_reg.bad_length;
    assign last_record    = q0_reg.last_record;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= sblf_pkg::FIFO_DEPTH)
        else $error("result queue count out of range");

    a_pair_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_record) |-> (q_cnt_reg == 2'd2))
        else $error("low record offered without its high record queued");

    a_bad_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_length) |-> (lane_mask == 8'd0 && record_data == 64'd0 && last_record))
        else $error("bad-length record carries data");

    a_no_adv_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!a_valid_reg) |=> (q_cnt_reg <= $past(q_cnt_reg)))
        else $error("queue grew without a store in the input register");
`endif

endmodule
